>>> src/blq_pkg.sv
// Shared types, constants and helper functions for the block index linked queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package blq_pkg;

   // Heap geometry. Both counts are powers of two, so index math is bit slicing.
   localparam int NUM_BLOCKS  = 4096;
   localparam int BLOCK_BYTES = 32768;
   localparam int IDX_W       = $clog2(NUM_BLOCKS);
   localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

   // Fixed field widths.
   localparam int ADDR_W = 48;
   localparam int LINK_W = 12;
   localparam int CMD_W  = 3;

   // Beat layouts.
   localparam int REQ_DATA_W    = 112;
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_END_LSB   = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_LINK_LSB  = REQ_END_LSB + ADDR_W;
   localparam int REQ_ISEND_BIT = REQ_LINK_LSB + LINK_W;
   localparam int RSP_DATA_W    = 56;
   localparam int RSP_VALID_BIT = ADDR_W;
   localparam int RSP_ERROR_BIT = ADDR_W + 1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LINK_W-1:0] link_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND       = 3'd0,
      CMD_APPEND_CHAIN = 3'd1,
      CMD_REMOVE       = 3'd2,
      CMD_CLEAR        = 3'd3,
      CMD_SET_LINK     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EXTRA
   } state_type;

   // One registered request, with addresses already turned into block indices.
   typedef struct packed {
      cmd_type  cmd;
      idx_type  blk_idx;
      idx_type  last_idx;
      link_type link;
      logic     is_end;
   } req_type;

   // Write requests into the two link tables.
   typedef struct packed {
      logic     next_we;
      idx_type  next_addr;
      link_type next_data;
      logic     end_we;
      idx_type  end_addr;
      logic     end_data;
   } mem_wr_type;

   // Byte address to block index: offset from the base, wrapped, then sliced.
   function automatic idx_type addr_to_index(input addr_type addr, input addr_type base);
      addr_type diff;
      diff = addr - base;
      return diff[BLK_SHIFT +: IDX_W];
   endfunction

   // Block index back to the aligned byte address of its block.
   function automatic addr_type index_to_addr(input idx_type idx, input addr_type base);
      addr_type offs;
      offs = ADDR_W'(idx) << BLK_SHIFT;
      return base + offs;
   endfunction

   // Block index as stored in a link entry.
   function automatic link_type idx_to_link(input idx_type idx);
      logic [LINK_W+IDX_W-1:0] ext;
      ext = {{LINK_W{1'b0}}, idx};
      return ext[LINK_W-1:0];
   endfunction

   // Follow a link: a zero code means the adjacent block; result wraps.
   function automatic idx_type link_target(input idx_type head, input link_type lnk);
      logic [LINK_W+IDX_W-1:0] ext;
      ext = {{IDX_W{1'b0}}, lnk};
      if (lnk == '0) begin
         return head + idx_type'(1);
      end
      return ext[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/blq_req_stage.sv
// Input register of the queue: captures one request beat and converts its
// addresses into block indices. Depends on blq_pkg.
`default_nettype none

module blq_req_stage
   import blq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [REQ_DATA_W-1:0] in_tdata,   // block_addr, chain_end_addr, link_index,
                                                  // link_is_end
   input  wire logic [CMD_W-1:0]      in_tuser,   // command
   input  wire addr_type              heap_base,
   output req_type                    req
);

   req_type  req_ff;
   req_type  req_in;
   cmd_type  cmd;
   addr_type blk_addr;
   addr_type end_addr;

   // Unpack the beat and compute both indices.
   always_comb begin
      cmd             = cmd_type'(in_tuser);
      blk_addr        = in_tdata[REQ_ADDR_LSB +: ADDR_W];
      end_addr        = in_tdata[REQ_END_LSB +: ADDR_W];
      req_in.cmd      = cmd;
      req_in.blk_idx  = addr_to_index(blk_addr, heap_base);
      req_in.link     = in_tdata[REQ_LINK_LSB +: LINK_W];
      req_in.is_end   = in_tdata[REQ_ISEND_BIT];
      // A single append ends at its own block.
      if (cmd == CMD_APPEND) begin
         req_in.last_idx = req_in.blk_idx;
      end else begin
         req_in.last_idx = addr_to_index(end_addr, heap_base);
      end
   end

   // Payload register, loaded on an accepted beat.
   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= req_in;
      end
   end

   assign req = req_ff;

endmodule

`default_nettype wire

>>> src/blq_link_mem.sv
// Link tables of the queue: next-block codes and end bits, one entry per block,
// with a clearing sweep after reset. Depends on blq_pkg.
`default_nettype none

module blq_link_mem
   import blq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire mem_wr_type wr,
   input  wire idx_type    rd_addr,
   output link_type        rd_next,
   output logic            rd_end,
   output logic            clr_busy
);

   link_type next_mem [NUM_BLOCKS];
   logic     end_mem  [NUM_BLOCKS];

   idx_type  clr_cnt_ff;
   idx_type  clr_cnt_in;
   logic     clr_busy_ff;
   logic     clr_busy_in;
   link_type rd_next_ff;
   logic     rd_end_ff;

   // Sweep counter: walks every entry once after reset.
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + idx_type'(1);
         if (clr_cnt_ff == idx_type'(NUM_BLOCKS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Next-code table: sweep writes zero, otherwise the requested write.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         next_mem[clr_cnt_ff] <= '0;
      end else if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_data;
      end
      rd_next_ff <= next_mem[rd_addr];
   end

   // End-bit table.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         end_mem[clr_cnt_ff] <= 1'b0;
      end else if (wr.end_we) begin
         end_mem[wr.end_addr] <= wr.end_data;
      end
      rd_end_ff <= end_mem[rd_addr];
   end

   assign rd_next  = rd_next_ff;
   assign rd_end   = rd_end_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

>>> src/block_index_linked_queue.sv
// Block index linked queue: a FIFO of heap blocks linked through per-block
// link tables. Top level; uses blq_pkg, blq_req_stage and blq_link_mem.
//
// Usage:
//   req_* carries one command beat (append, append chain, remove first, clear,
//   set link); rsp_* returns exactly one result beat per command with the
//   removed address and the removed, error and list-empty flags.
//   csr_* writes the heap base address; write it only while the queue is idle.
// Timing:
//   A beat accepted at one edge reads the link entry of the current head at
//   that edge; its result is registered once the output register is free.
//   A new beat is taken only in the idle state. Appends also pass through
//   ST_EXTRA, because the old tail's end bit and the new tail's end bit go
//   through the single write port of the end-bit table in separate states.
// Reset:
//   The list becomes empty, the heap base returns to zero, and the link tables
//   are swept to zero one entry per cycle, while req_tready stays low. csr
//   writes are taken at any time.
// Back pressure:
//   A result waiting on rsp_tready holds in the output register; the next beat
//   may still be accepted, and its own result waits until the register frees.
`default_nettype none

module block_index_linked_queue
   import blq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // block_addr, chain_end_addr, link_index,
                                                  // link_is_end, zero pad
   input  wire logic [CMD_W-1:0]      req_tuser,  // command
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // removed_addr, removed_valid,
                                                  // empty_error, list_empty, zero pad
   // Heap base register write.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [ADDR_W-1:0]     csr_data
);

   addr_type              heap_base_ff;
   state_type             state_ff;
   state_type             state_in;
   idx_type               head_ff;
   idx_type               head_in;
   idx_type               tail_ff;
   idx_type               tail_in;
   logic                  empty_ff;
   logic                  empty_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                  req_accept;
   logic                  exec_fire;
   req_type               req;
   mem_wr_type            mem_wr;
   link_type              rd_next;
   logic                  rd_end;
   logic                  clr_busy;

   assign req_tready = (state_ff == ST_IDLE) && !clr_busy;
   assign req_accept = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // Input register and index conversion.
   blq_req_stage u_req_stage (
      .clock     (clock),
      .load      (req_accept),
      .in_tdata  (req_tdata),
      .in_tuser  (req_tuser),
      .heap_base (heap_base_ff),
      .req       (req)
   );

   // Link tables, always reading the entry of the current head.
   blq_link_mem u_link_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (mem_wr),
      .rd_addr  (head_ff),
      .rd_next  (rd_next),
      .rd_end   (rd_end),
      .clr_busy (clr_busy)
   );

   // Heap base register.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         heap_base_ff <= csr_data;
      end
   end

   // Sequencer: executes the registered command and fills the result register.
   always_comb begin
      addr_type removed;
      logic     rem_valid;
      logic     rem_err;

      removed      = '0;
      rem_valid    = 1'b0;
      rem_err      = 1'b0;
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      mem_wr       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
               case (req.cmd)
                  CMD_APPEND, CMD_APPEND_CHAIN: begin
                     // Link the old tail to the new first block, or start the list with it when empty.
                     if (empty_ff) begin
                        head_in = req.blk_idx;
                     end else begin
                        mem_wr.next_we   = 1'b1;
                        mem_wr.next_addr = tail_ff;
                        mem_wr.next_data = idx_to_link(req.blk_idx);
                        mem_wr.end_we    = 1'b1;
                        mem_wr.end_addr  = tail_ff;
                        mem_wr.end_data  = 1'b0;
                     end
                     tail_in  = req.last_idx;
                     empty_in = 1'b0;
                     state_in = ST_EXTRA;
                  end
                  CMD_REMOVE: begin
                     if (empty_ff) begin
                        rem_err = 1'b1;
                     end else begin
                        removed   = index_to_addr(head_ff, heap_base_ff);
                        rem_valid = 1'b1;
                        if ((head_ff == tail_ff) || rd_end) begin
                           empty_in = 1'b1;
                        end else begin
                           head_in = link_target(head_ff, rd_next);
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     empty_in = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                  end
                  CMD_SET_LINK: begin
                     mem_wr.next_we   = 1'b1;
                     mem_wr.next_addr = req.blk_idx;
                     mem_wr.next_data = req.link;
                     mem_wr.end_we    = 1'b1;
                     mem_wr.end_addr  = req.blk_idx;
                     mem_wr.end_data  = req.is_end;
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({empty_in, rem_err, rem_valid, removed});
            end
         end
         ST_EXTRA: begin
            // Mark the new tail as the end of the list.
            mem_wr.end_we   = 1'b1;
            mem_wr.end_addr = req.last_idx;
            mem_wr.end_data = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // No command is taken while the link tables are being swept.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_tready)
      else $error("command accepted during link table sweep");

   // Only appends need the extra end-bit write state.
   a_extra_only_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && state_in == ST_EXTRA) |->
         (req.cmd == CMD_APPEND || req.cmd == CMD_APPEND_CHAIN))
      else $error("extra cycle entered by a non-append command");

   // Clear leaves an empty list at index zero.
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && req.cmd == CMD_CLEAR) |=>
         (empty_ff && head_ff == '0 && tail_ff == '0))
      else $error("clear did not empty the list");

   // Removing from a non-empty list always reports a removed block.
   a_remove_reports: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && req.cmd == CMD_REMOVE && !empty_ff) |=>
         (rsp_valid_ff && rsp_data_ff[RSP_VALID_BIT] && !rsp_data_ff[RSP_ERROR_BIT]))
      else $error("remove from non-empty list not reported");

   // A result never claims both a removal and an empty-list error.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[RSP_VALID_BIT] && rsp_data_ff[RSP_ERROR_BIT]))
      else $error("removed and error flags both set");

endmodule

`default_nettype wire
